// File: hw/rtl/dhfk_pkg.sv
package dhfk_pkg;

  // Angle resolution: top bits of the 16-bit turn fraction that are used
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] PHASE_MASK =
    32'((64'hFFFF_FFFF >> (32 - ANGLE_BITS)) << (32 - ANGLE_BITS));
  localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

  typedef struct packed {
    logic               first_link;
    logic [15:0]        twist_angle;
    logic signed [31:0] link_length;
    logic signed [31:0] link_offset;
    logic [15:0]        joint_angle;
    logic               report_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               saturated;
  } out_item_t;

  // arctangent of 2^-i in turns, scaled by 2^32
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh20000000;
      5'd1:  v = 34'sh12E4051E;
      5'd2:  v = 34'sh09FB385B;
      5'd3:  v = 34'sh051111D4;
      5'd4:  v = 34'sh028B0D43;
      5'd5:  v = 34'sh0145D7E1;
      5'd6:  v = 34'sh00A2F61E;
      5'd7:  v = 34'sh00517C55;
      5'd8:  v = 34'sh0028BE53;
      5'd9:  v = 34'sh00145F2F;
      5'd10: v = 34'sh000A2F98;
      5'd11: v = 34'sh000517CC;
      5'd12: v = 34'sh00028BE6;
      5'd13: v = 34'sh000145F3;
      5'd14: v = 34'sh0000A2FA;
      5'd15: v = 34'sh0000517D;
      5'd16: v = 34'sh000028BE;
      5'd17: v = 34'sh0000145F;
      5'd18: v = 34'sh00000A30;
      5'd19: v = 34'sh00000518;
      5'd20: v = 34'sh0000028C;
      5'd21: v = 34'sh00000146;
      5'd22: v = 34'sh000000A3;
      5'd23: v = 34'sh00000051;
      5'd24: v = 34'sh00000029;
      5'd25: v = 34'sh00000014;
      5'd26: v = 34'sh0000000A;
      5'd27: v = 34'sh00000005;
      5'd28: v = 34'sh00000003;
      5'd29: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product scaled down by 2^30, rounded half up
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + ROUND_HALF;
    return t[63:30];
  endfunction

  function automatic logic sat_hit(input logic signed [35:0] v);
    return (v[35:31] != {5{v[31]}});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (!sat_hit(v)) r = v[31:0];
    else if (v[35])  r = 32'sh8000_0000;
    else             r = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

// File: hw/rtl/dhfk_front.sv
module dhfk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  dhfk_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output dhfk_pkg::in_item_t cmd,
  input  logic              cmd_take
);
  import dhfk_pkg::*;

  // two-entry item queue between the input port and the executor
  in_item_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = buf_r[rp_r];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// File: hw/rtl/dhfk_outq.sv
module dhfk_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  dhfk_pkg::out_item_t wr_data,
  output logic               wr_full,
  output logic               empty,
  input  logic               pop,
  output dhfk_pkg::out_item_t out_data
);
  import dhfk_pkg::*;

  // two-entry result queue
  out_item_t  buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_full  = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_data = buf_r[rp_r];
  assign do_wr    = wr && !wr_full;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// File: hw/rtl/dhfk_back.sv
module dhfk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  dhfk_pkg::in_item_t cmd,
  output logic               cmd_take,
  output logic               res_wr,
  output dhfk_pkg::out_item_t res_data,
  input  logic               res_full
);
  import dhfk_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CORDIC = 7'b0000010,
    ST_LMUL   = 7'b0000100,
    ST_LWB    = 7'b0001000,
    ST_CMUL   = 7'b0010000,
    ST_CWB    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r;

  // item fields held for the whole link
  logic               first_r, report_r;
  logic signed [31:0] len_r, off_r;

  // two CORDIC rotators: joint angle (j) and twist angle (a)
  logic signed [33:0] xj_r, yj_r, zj_r, xa_r, ya_r, za_r;
  logic               flipj_r, flipa_r;
  logic [4:0]         it_r;

  // link transform products and running transform
  logic signed [31:0] lr3_r, lr4_r, lr6_r, lr7_r, lp1_r, lp2_r;
  logic signed [31:0] rot_r [9];
  logic signed [31:0] tr_r [3];
  logic signed [31:0] row_r [3];

  // shared multiplier and accumulator
  logic signed [63:0] prod_r;
  logic signed [35:0] acc_r;
  logic [2:0]         op_r;
  logic [1:0]         r_r, c_r, k_r;
  logic               clip_link_r, clip_chain_r, clip_seen_r;

  logic signed [31:0] ct, st, ca, sa;
  logic signed [31:0] lr [9];
  logic signed [31:0] mul_a, mul_b;
  logic signed [33:0] m;
  logic signed [35:0] m36, sum36, base36;
  logic [3:0]         ridx, lidx;
  logic [15:0]        jang, tang;
  logic [31:0]        phj, pha;
  logic               fj, fa;

  // sine and cosine with quadrant fold undone
  always_comb begin
    ct = flipj_r ? -xj_r[31:0] : xj_r[31:0];
    st = flipj_r ? -yj_r[31:0] : yj_r[31:0];
    ca = flipa_r ? -xa_r[31:0] : xa_r[31:0];
    sa = flipa_r ? -ya_r[31:0] : ya_r[31:0];
  end

  // link rotation, row major
  always_comb begin
    lr[0] = ct;    lr[1] = -st;   lr[2] = '0;
    lr[3] = lr3_r; lr[4] = lr4_r; lr[5] = -sa;
    lr[6] = lr6_r; lr[7] = lr7_r; lr[8] = ca;
  end

  // phase setup for the rotators
  always_comb begin
    jang = cmd.joint_angle;
    tang = cmd.twist_angle;
    phj  = {jang, 16'h0} & PHASE_MASK;
    pha  = {tang, 16'h0} & PHASE_MASK;
    fj   = phj[31] ^ phj[30];
    fa   = pha[31] ^ pha[30];
  end

  // multiplier operand select
  always_comb begin
    ridx  = 4'(r_r) * 4'd3 + 4'(k_r);
    lidx  = 4'(k_r) * 4'd3 + 4'(c_r);
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_LMUL) begin
      case (op_r)
        3'd0:    begin mul_a = st; mul_b = ca;    end
        3'd1:    begin mul_a = ct; mul_b = ca;    end
        3'd2:    begin mul_a = st; mul_b = sa;    end
        3'd3:    begin mul_a = ct; mul_b = sa;    end
        3'd4:    begin mul_a = sa; mul_b = off_r; end
        default: begin mul_a = ca; mul_b = off_r; end
      endcase
    end else begin
      mul_a = rot_r[ridx];
      if (c_r == 2'd3) begin
        case (k_r)
          2'd0:    mul_b = len_r;
          2'd1:    mul_b = lp1_r;
          default: mul_b = lp2_r;
        endcase
      end else begin
        mul_b = lr[lidx];
      end
    end
  end

  // rounding and accumulation of the registered product
  always_comb begin
    m      = round_q30(prod_r);
    m36    = 36'(m);
    base36 = (c_r == 2'd3) ? 36'(tr_r[r_r]) : '0;
    sum36  = ((k_r == 2'd0) ? base36 : acc_r) + m36;
  end

  assign cmd_take = (state_r == ST_IDLE) && cmd_valid;
  assign res_wr   = (state_r == ST_DONE) && report_r && !res_full;
  always_comb begin
    res_data.pos_x     = tr_r[0];
    res_data.pos_y     = tr_r[1];
    res_data.pos_z     = tr_r[2];
    res_data.saturated = clip_seen_r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        first_r  <= cmd.first_link;
        report_r <= cmd.report_position;
        len_r    <= cmd.link_length;
        off_r    <= cmd.link_offset;
        flipj_r  <= fj;
        flipa_r  <= fa;
        xj_r <= CORDIC_GAIN;
        yj_r <= '0;
        zj_r <= 34'(signed'({phj[31] ^ fj, phj[30:0]}));
        xa_r <= CORDIC_GAIN;
        ya_r <= '0;
        za_r <= 34'(signed'({pha[31] ^ fa, pha[30:0]}));
        it_r <= '0;
      end
      ST_CORDIC: begin
        if (!zj_r[33]) begin
          xj_r <= xj_r - (yj_r >>> it_r);
          yj_r <= yj_r + (xj_r >>> it_r);
          zj_r <= zj_r - atan_turn(it_r);
        end else begin
          xj_r <= xj_r + (yj_r >>> it_r);
          yj_r <= yj_r - (xj_r >>> it_r);
          zj_r <= zj_r + atan_turn(it_r);
        end
        if (!za_r[33]) begin
          xa_r <= xa_r - (ya_r >>> it_r);
          ya_r <= ya_r + (xa_r >>> it_r);
          za_r <= za_r - atan_turn(it_r);
        end else begin
          xa_r <= xa_r + (ya_r >>> it_r);
          ya_r <= ya_r - (xa_r >>> it_r);
          za_r <= za_r + atan_turn(it_r);
        end
        it_r <= it_r + 5'd1;
      end
      ST_LWB: begin
        case (op_r)
          3'd0: lr3_r <= m[31:0];
          3'd1: lr4_r <= m[31:0];
          3'd2: lr6_r <= m[31:0];
          3'd3: lr7_r <= m[31:0];
          3'd4: lp1_r <= sat32(-m36);
          default: begin
            lp2_r <= sat32(m36);
            if (first_r) begin
              for (int i = 0; i < 9; i++) rot_r[i] <= lr[i];
              tr_r[0] <= len_r;
              tr_r[1] <= lp1_r;
              tr_r[2] <= sat32(m36);
            end
          end
        endcase
      end
      ST_CWB: begin
        acc_r <= sum36;
        if (k_r == 2'd2) begin
          if (c_r == 2'd3) begin
            tr_r[r_r] <= sat32(sum36);
            for (int i = 0; i < 3; i++) rot_r[4'(r_r) * 4'd3 + 4'(i)] <= row_r[i];
          end else begin
            row_r[c_r] <= sat32(sum36);
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer and clip flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= '0;
      r_r          <= '0;
      c_r          <= '0;
      k_r          <= '0;
      clip_link_r  <= 1'b0;
      clip_chain_r <= 1'b0;
      clip_seen_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) state_r <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (it_r == 5'(CORDIC_STEPS - 1)) begin
            state_r     <= ST_LMUL;
            op_r        <= '0;
            clip_link_r <= 1'b0;
          end
        end
        ST_LMUL: state_r <= ST_LWB;
        ST_LWB: begin
          if (op_r == 3'd4) clip_link_r <= sat_hit(-m36);
          if (op_r == 3'd5) begin
            if (first_r) begin
              clip_seen_r <= clip_link_r | sat_hit(m36);
              state_r     <= ST_DONE;
            end else begin
              clip_link_r  <= clip_link_r | sat_hit(m36);
              clip_chain_r <= 1'b0;
              r_r <= '0;
              c_r <= '0;
              k_r <= '0;
              state_r <= ST_CMUL;
            end
          end else begin
            op_r    <= op_r + 3'd1;
            state_r <= ST_LMUL;
          end
        end
        ST_CMUL: state_r <= ST_CWB;
        ST_CWB: begin
          state_r <= ST_CMUL;
          if (k_r == 2'd2) begin
            k_r <= '0;
            if (c_r == 2'd3) begin
              c_r <= '0;
              clip_chain_r <= clip_chain_r | sat_hit(sum36);
              if (r_r == 2'd2) begin
                clip_seen_r <= clip_seen_r | clip_link_r | clip_chain_r |
                               sat_hit(sum36);
                state_r <= ST_DONE;
              end else begin
                r_r <= r_r + 2'd1;
              end
            end else begin
              c_r <= c_r + 2'd1;
            end
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_DONE: begin
          if (!report_r || !res_full) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/dh_forward_kinematics_chain.sv
// Serial-chain forward kinematics, modified Denavit-Hartenberg form, one
// link per item. Each item carries the link twist, length, offset and
// joint angle; the block builds the link transform and multiplies it onto
// the running transform (a first_link item loads it instead). With
// report_position set, one result gives the frame origin x, y, z in Q16.16
// and a sticky saturation flag for the chain. Angles are 16-bit turn
// fractions; rotation entries are Q2.30. Items queue in a two-entry input
// buffer, results in a two-entry output buffer. Per item the block takes
// the item, runs the CORDIC (both angles rotate side by side), then
// uses one shared 32x32 multiplier for 6 products for the link itself
// and 36 more to chain onto the running transform (a first link skips
// these), then hands off the result; a full result queue stretches the
// hand-off.
module dh_forward_kinematics_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  dhfk_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output dhfk_pkg::out_item_t out_data
);
  import dhfk_pkg::*;

  logic      cmd_valid, cmd_take, res_wr, res_full;
  in_item_t  cmd;
  out_item_t res_data;

  // input queue
  dhfk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // transform engine
  dhfk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_wr    (res_wr),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // result queue
  dhfk_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (res_wr),
    .wr_data  (res_data),
    .wr_full  (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// File: tb/dh_forward_kinematics_chain_checker.sv
module dh_forward_kinematics_chain_checker
  import dhfk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_data,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        reports,
  output int        clipped_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  // arctangent of 2^-i in turns, scaled by 2^32
  localparam longint ATAN_TURN[30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };
  localparam longint GAIN    = 64'd652032874;
  localparam longint S32_HI  = 64'sd2147483647;
  localparam longint S32_LO  = -64'sd2147483648;

  // running chain transform: rotation Q2.30 row major, origin Q16.16
  longint    chain_rot[9];
  longint    chain_org[3];
  bit        chain_clip;
  out_item_t expected_pos_q[$];

  // Q2.30 product, rounded half up
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clamp32(input longint v, inout bit hit);
    if (v > S32_HI) begin
      hit = 1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      hit = 1;
      return S32_LO;
    end
    return v;
  endfunction

  // CORDIC cosine and sine of a turn fraction, Q2.30
  function automatic void turn_sin_cos(input logic [15:0] ang, output longint c,
                                       output longint s);
    longint ph, x, y, z, dx, dy;
    bit     flip;
    ph   = longint'({32'b0, ang, 16'b0}) & longint'({32'b0, PHASE_MASK});
    flip = ((ph >> 30) == 1) || ((ph >> 30) == 2);
    x = GAIN;
    y = 0;
    if (flip) ph = (ph + 64'h80000000) & 64'hFFFFFFFF;
    z = (ph >= 64'h80000000) ? ph - 64'h100000000 : ph;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // apply one link to the chain; queue a position if one is asked for
  function automatic void apply_link(input in_item_t it);
    longint ct, st, ca, sa, acc, sum;
    longint lr[9], lp[3], nr[9], np[3];
    bit     hit, unused;
    out_item_t pos;
    hit = 0;
    unused = 0;
    turn_sin_cos(it.joint_angle, ct, st);
    turn_sin_cos(it.twist_angle, ca, sa);
    lr = '{ct, -st, 0, mul_q30(st, ca), mul_q30(ct, ca), -sa,
           mul_q30(st, sa), mul_q30(ct, sa), ca};
    lp[0] = longint'(it.link_length);
    lp[1] = clamp32(-mul_q30(sa, longint'(it.link_offset)), hit);
    lp[2] = clamp32(mul_q30(ca, longint'(it.link_offset)), hit);
    if (it.first_link) begin
      for (int k = 0; k < 9; k++) chain_rot[k] = clamp32(lr[k], unused);
      for (int k = 0; k < 3; k++) chain_org[k] = lp[k];
      chain_clip = hit;
    end else begin
      for (int r = 0; r < 3; r++) begin
        acc = chain_org[r];
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += mul_q30(chain_rot[r*3+k], lr[k*3+c]);
          nr[r*3+c] = clamp32(sum, unused);
        end
        for (int k = 0; k < 3; k++) acc += mul_q30(chain_rot[r*3+k], lp[k]);
        np[r] = clamp32(acc, hit);
      end
      chain_rot = nr;
      chain_org = np;
      chain_clip = chain_clip || hit;
    end
    if (it.report_position) begin
      pos.pos_x = 32'(chain_org[0]);
      pos.pos_y = 32'(chain_org[1]);
      pos.pos_z = 32'(chain_org[2]);
      pos.saturated = chain_clip;
      expected_pos_q.push_back(pos);
    end
  endfunction

  initial begin
    fail_count = 0;
    reports = 0;
    clipped_reports = 0;
    chain_clip = 0;
    for (int k = 0; k < 9; k++) chain_rot[k] = 0;
    for (int k = 0; k < 3; k++) chain_org[k] = 0;
  end

  assign pending = expected_pos_q.size();

  // compare each popped position with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_pos_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                   out_data.pos_x, out_data.pos_y, out_data.pos_z, out_data.saturated);
        end else begin
          want = expected_pos_q.pop_front();
          reports++;
          if (want.saturated) clipped_reports++;
          if (out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
              out_data.pos_z !== want.pos_z || out_data.saturated !== want.saturated) begin
            fail_count++;
            $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b", $time,
                     want.pos_x, want.pos_y, want.pos_z, want.saturated);
            $display("%0t:            actual x=%h y=%h z=%h sat=%b", $time,
                     out_data.pos_x, out_data.pos_y, out_data.pos_z, out_data.saturated);
          end
        end
      end
      if (push && !full) apply_link(in_data);
    end
  end

endmodule

// File: tb/dh_forward_kinematics_chain_test.sv
module dh_forward_kinematics_chain_test;
  import dhfk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINK_COUNT  = 1050;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 600;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      push = 0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 0;
  out_item_t out_data;
  int        fail_count, pending, reports, clipped_reports;
  int        cycles = 0;
  int        links_sent = 0;
  int        burst_left = 0;
  bit        hold_req = 0;

  always #1 clk = ~clk;

  dh_forward_kinematics_chain dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  dh_forward_kinematics_chain_checker chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .fail_count(fail_count),
    .pending(pending), .reports(reports), .clipped_reports(clipped_reports)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: stall mode is redrawn at random from four modes; one long hold on request
  always @(negedge clk) begin
    int hold_left;
    int pop_mode;
    if (hold_req) begin
      hold_req = 0;
      hold_left = LONG_HOLD;
    end
    if (cycles % 64 == 0) pop_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      pop <= 0;
    end else begin
      case (pop_mode)
        0:       pop <= 1;
        1:       pop <= ($urandom_range(0, 1) == 1);
        2:       pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // offer one link, in bursts with random gaps; returns at a falling edge
  task automatic send_link(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        push <= 0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    push <= 1;
    in_data <= it;
    do @(posedge clk); while (full);
    links_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom();
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 7)) << 13;
    return 16'($urandom());
  endfunction

  function automatic in_item_t make_link(input bit first, input logic [15:0] twist,
                                         input logic signed [31:0] len,
                                         input logic signed [31:0] off,
                                         input logic [15:0] joint, input bit report);
    in_item_t it;
    it.first_link = first;
    it.twist_angle = twist;
    it.link_length = len;
    it.link_offset = off;
    it.joint_angle = joint;
    it.report_position = report;
    return it;
  endfunction

  initial begin
    int chain_len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: quadrant angles, back-to-back first links, field extremes,
    // and chains that clip the position and keep the sticky flag
    send_link(make_link(1, 16'h0000, 32'sh0001_0000, 32'sh0002_0000, 16'h0000, 1));
    send_link(make_link(1, 16'h4000, 32'sh0001_0000, 32'sh0002_0000, 16'h4000, 1));
    send_link(make_link(0, 16'h8000, 32'sh0003_0000, -32'sh0001_0000, 16'h8000, 1));
    send_link(make_link(0, 16'hC000, -32'sh0002_0000, 32'sh0001_8000, 16'hC000, 1));
    send_link(make_link(0, 16'hFFFF, 32'sh0000_0001, 32'sh0000_0001, 16'hFFFF, 0));
    send_link(make_link(0, 16'h2000, 32'sh0000_0000, 32'sh0000_0000, 16'h6000, 1));
    send_link(make_link(1, 16'h0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000, 1));
    send_link(make_link(0, 16'h0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000, 1));
    send_link(make_link(0, 16'h0000, 32'sh0000_0000, 32'sh0000_0000, 16'h0000, 1));
    send_link(make_link(1, 16'h8000, 32'sh8000_0000, 32'sh8000_0000, 16'h8000, 1));
    send_link(make_link(0, 16'h8000, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 1));
    send_link(make_link(1, 16'hC000, 32'sh8000_0000, 32'sh8000_0000, 16'h4000, 1));
    send_link(make_link(1, 16'h4000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hC000, 1));
    send_link(make_link(1, 16'h1234, 32'sh0000_8000, 32'sh0000_4000, 16'hABCD, 0));
    send_link(make_link(0, 16'h5555, 32'sh0001_0000, 32'sh0000_0000, 16'hAAAA, 0));
    send_link(make_link(0, 16'hAAAA, 32'sh0000_0000, 32'sh0001_0000, 16'h5555, 1));
    send_link(make_link(1, 16'hFFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'hFFFF, 1));

    // random chains of random length, each opened by a first link
    while (links_sent < LINK_COUNT) begin
      chain_len = $urandom_range(1, 10);
      for (int k = 0; k < chain_len; k++) begin
        if (links_sent == 400) hold_req = 1;
        send_link(make_link(k == 0 || $urandom_range(0, 29) == 0, rand_angle(),
                            rand_len(), rand_len(), rand_angle(),
                            $urandom_range(0, 2) != 0));
      end
    end
    push <= 0;

    // drain, then allow for one more item's worth of latency
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("covered %0d links, %0d positions checked, %0d of them clipped",
             links_sent, reports, clipped_reports);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
